FILE: hw/rtl/cskc_pkg.sv
// ----------------------------------------------------------------------------
// cskc_pkg
// Types, codes and limits shared by the clock setting key controller.
// ----------------------------------------------------------------------------
package cskc_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_DEC  = 2'd1;
  localparam logic [1:0] KIND_INC  = 2'd2;
  localparam logic [1:0] KIND_SEL  = 2'd3;

  // Field select codes.
  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;

  // Field limits.
  localparam logic [7:0] YEAR_FLOOR = 8'd70;
  localparam logic [7:0] YEAR_CEIL  = 8'd255;
  localparam logic [3:0] MONTH_MAX  = 4'd11;
  localparam logic [4:0] DAY_MIN    = 5'd1;
  localparam logic [4:0] DAY_MAX    = 5'd31;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  localparam logic [14:0] BLINK_RESET = 15'd500;
  localparam logic [15:0] BLINK_SAT   = 16'hFFFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } item_t;

  typedef struct packed {
    logic       setting_mode;
    logic [2:0] selected_field;
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       rtc_write;
    logic       cursor_on;
  } result_t;

endpackage

FILE: hw/rtl/cskc_in_reg.sv
// ----------------------------------------------------------------------------
// cskc_in_reg
// Input register: captures one beat and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module cskc_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cskc_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output cskc_pkg::item_t item
);
  import cskc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  // A held item that the core cannot take this cycle blocks the input.
  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: hw/rtl/cskc_core.sv
// ----------------------------------------------------------------------------
// cskc_core
// Mode, field select, edit registers and blink counter, updated once per item.
// ----------------------------------------------------------------------------
module cskc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [14:0]      half_period,
  input  logic             fire,
  input  cskc_pkg::item_t  item,
  output cskc_pkg::result_t result
);
  import cskc_pkg::*;

  logic        mode_r,   mode_nxt;
  logic [2:0]  field_r,  field_nxt;
  logic [7:0]  year_r,   year_nxt;
  logic [3:0]  month_r,  month_nxt;
  logic [4:0]  day_r,    day_nxt;
  logic [4:0]  hour_r,   hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [15:0] blink_r,  blink_nxt;
  logic [15:0] blink_inc;
  logic [16:0] twice;
  logic        write;
  logic        up;

  assign twice = {1'b0, half_period, 1'b0};
  assign up    = (item.kind == KIND_INC);
  assign blink_inc = (blink_r != BLINK_SAT) ? blink_r + 16'd1 : blink_r;

  always_comb begin
    mode_nxt   = mode_r;
    field_nxt  = field_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    blink_nxt  = blink_r;
    write      = 1'b0;
    unique case (item.kind)
      KIND_TICK: begin
        blink_nxt = blink_inc;
        if (mode_r && ({1'b0, blink_inc} > twice)) begin
          blink_nxt = '0;
        end
      end
      KIND_SEL: begin
        if (!mode_r) begin
          year_nxt   = item.year;
          month_nxt  = item.month;
          day_nxt    = item.day;
          hour_nxt   = item.hour;
          minute_nxt = item.minute;
          second_nxt = item.second;
          field_nxt  = FLD_YEAR;
          mode_nxt   = 1'b1;
        end else if (field_r >= FLD_SECOND) begin
          write    = 1'b1;
          mode_nxt = 1'b0;
        end else begin
          field_nxt = field_r + 3'd1;
        end
      end
      default: begin
        if (mode_r) begin
          unique case (field_r)
            FLD_YEAR: begin
              if (up) begin
                year_nxt = (year_r == YEAR_CEIL) ? YEAR_CEIL : year_r + 8'd1;
              end else begin
                year_nxt = (year_r <= YEAR_FLOOR) ? YEAR_FLOOR : year_r - 8'd1;
              end
            end
            FLD_MONTH: begin
              if (up) begin
                month_nxt = (month_r >= MONTH_MAX) ? 4'd0 : month_r + 4'd1;
              end else begin
                month_nxt = (month_r == 4'd0) ? MONTH_MAX : month_r - 4'd1;
              end
            end
            FLD_DAY: begin
              if (up) begin
                day_nxt = (day_r >= DAY_MAX) ? DAY_MIN : day_r + 5'd1;
              end else begin
                day_nxt = (day_r <= DAY_MIN) ? DAY_MAX : day_r - 5'd1;
              end
            end
            FLD_HOUR: begin
              if (up) begin
                hour_nxt = (hour_r >= HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
              end else begin
                hour_nxt = (hour_r == 5'd0) ? HOUR_MAX : hour_r - 5'd1;
              end
            end
            FLD_MINUTE: begin
              if (up) begin
                minute_nxt = (minute_r >= MINSEC_MAX) ? 6'd0 : minute_r + 6'd1;
              end else begin
                minute_nxt = (minute_r == 6'd0) ? MINSEC_MAX : minute_r - 6'd1;
              end
            end
            FLD_SECOND: begin
              if (up) begin
                second_nxt = (second_r >= MINSEC_MAX) ? 6'd0 : second_r + 6'd1;
              end else begin
                second_nxt = (second_r == 6'd0) ? MINSEC_MAX : second_r - 6'd1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      field_r  <= FLD_YEAR;
      year_r   <= YEAR_FLOOR;
      month_r  <= 4'd0;
      day_r    <= DAY_MIN;
      hour_r   <= 5'd0;
      minute_r <= 6'd0;
      second_r <= 6'd0;
      blink_r  <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      field_r  <= field_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      blink_r  <= blink_nxt;
    end
  end

  always_comb begin
    result.setting_mode   = mode_nxt;
    result.selected_field = field_nxt;
    result.year           = year_nxt;
    result.month          = month_nxt;
    result.day            = day_nxt;
    result.hour           = hour_nxt;
    result.minute         = minute_nxt;
    result.second         = second_nxt;
    result.rtc_write      = write;
    result.cursor_on      = mode_nxt && (blink_nxt > {1'b0, half_period})
                            && ({1'b0, blink_nxt} <= twice);
  end

endmodule

FILE: hw/rtl/cskc_out_reg.sv
// ----------------------------------------------------------------------------
// cskc_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module cskc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cskc_pkg::result_t result,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_stall,
  output cskc_pkg::result_t held
);
  import cskc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t held_r;

  assign can_load  = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign held      = held_r;

endmodule

FILE: hw/rtl/clock_setting_key_controller_unit.sv
// ----------------------------------------------------------------------------
// clock_setting_key_controller_unit
// Time-setting controller for a clock, driven by key and tick beats.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+--------------------------------------
//   in_      | in_valid / in_stall  | kind and the current clock time
//   out_     | out_valid / out_stall| mode, field, edited time, strobes
//   cfg_     | cfg_wr_en            | cfg_wr_data, blink half period
//
// Every input beat yields exactly one result beat. An accepted beat is held
// in the input register until the result register can take its result; the
// update is then written into the result register, which offers the result.
// A new beat is accepted in every cycle while results flow.
// Reset (rst_n low at a clock edge) returns to normal mode with the edit
// registers at year 70, January, day 1, 00:00:00 and a half period of 500.
// A stalled result holds; the input stalls only when the input register is
// full and the result register cannot be refilled.
//
module clock_setting_key_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rtc_year_offset,
  input  logic [3:0]  in_rtc_month,
  input  logic [4:0]  in_rtc_day,
  input  logic [4:0]  in_rtc_hour,
  input  logic [5:0]  in_rtc_minute,
  input  logic [5:0]  in_rtc_second,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_setting_mode,
  output logic [2:0]  out_selected_field,
  output logic [7:0]  out_year_offset,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour_value,
  output logic [5:0]  out_minute_value,
  output logic [5:0]  out_second_value,
  output logic        out_rtc_write,
  output logic        out_cursor_on
);
  import cskc_pkg::*;

  logic [14:0] half_period_r;
  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        can_load;
  logic        fire;
  result_t     result;
  result_t     held;

  // The user must write the blink half period only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= BLINK_RESET;
    end else if (cfg_wr_en) begin
      half_period_r <= cfg_wr_data;
    end
  end

  always_comb begin
    in_item.kind   = in_kind;
    in_item.year   = in_rtc_year_offset;
    in_item.month  = in_rtc_month;
    in_item.day    = in_rtc_day;
    in_item.hour   = in_rtc_hour;
    in_item.minute = in_rtc_minute;
    in_item.second = in_rtc_second;
  end

  // The held item is processed in the cycle in which the result register
  // can accept its result; the state registers advance in that same cycle.
  assign fire = item_valid && can_load;

  cskc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (can_load),
    .item_valid (item_valid),
    .item       (item)
  );

  cskc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .half_period (half_period_r),
    .fire        (fire),
    .item        (item),
    .result      (result)
  );

  cskc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .result    (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign out_setting_mode   = held.setting_mode;
  assign out_selected_field = held.selected_field;
  assign out_year_offset    = held.year;
  assign out_month_index    = held.month;
  assign out_day_of_month   = held.day;
  assign out_hour_value     = held.hour;
  assign out_minute_value   = held.minute;
  assign out_second_value   = held.second;
  assign out_rtc_write      = held.rtc_write;
  assign out_cursor_on      = held.cursor_on;

endmodule

FILE: hw/rtl/cskc_checker.sv
// ----------------------------------------------------------------------------
// cskc_checker
// Port-level checks for the clock setting key controller.
// ----------------------------------------------------------------------------
module cskc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_setting_mode,
  input logic [2:0] out_selected_field,
  input logic       out_rtc_write,
  input logic       out_cursor_on
);
  import cskc_pkg::*;

  // A stalled result beat stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // The commit strobe always comes with the return to normal mode.
  a_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rtc_write |-> !out_setting_mode)
    else $error("commit strobe while still in setting mode");

  // The cursor is only shown while setting the time.
  a_cursor_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cursor_on |-> out_setting_mode)
    else $error("cursor shown in normal mode");

  // The selected field never goes past the second.
  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_selected_field <= FLD_SECOND)
    else $error("selected field out of range");

endmodule

bind clock_setting_key_controller_unit cskc_checker u_cskc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_setting_mode   (out_setting_mode),
  .out_selected_field (out_selected_field),
  .out_rtc_write      (out_rtc_write),
  .out_cursor_on      (out_cursor_on)
);

FILE: tb/tb_clock_setting_key_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_clock_setting_key_controller_unit
// Self-checking bench for the clock time-setting key controller. Key and tick
// beats go in through the valid/stall input channel. A cycle-free model of the
// setting state machine predicts one result beat per input beat. Every result
// beat is compared field by field against that prediction, in order. The run
// steps through several blink half periods, including zero, one and the
// largest value.
// ----------------------------------------------------------------------------
module tb_clock_setting_key_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cskc_pkg::*;

  // Generous cap on the run length, in clock cycles.
  localparam int CYCLE_LIMIT = 50_000;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n              = 1'b0;
  logic        cfg_wr_en          = 1'b0;
  logic [14:0] cfg_wr_data        = '0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind            = KIND_TICK;
  logic [7:0]  in_rtc_year_offset = '0;
  logic [3:0]  in_rtc_month       = '0;
  logic [4:0]  in_rtc_day         = DAY_MIN;
  logic [4:0]  in_rtc_hour        = '0;
  logic [5:0]  in_rtc_minute      = '0;
  logic [5:0]  in_rtc_second      = '0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  logic        out_setting_mode;
  logic [2:0]  out_selected_field;
  logic [7:0]  out_year_offset;
  logic [3:0]  out_month_index;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour_value;
  logic [5:0]  out_minute_value;
  logic [5:0]  out_second_value;
  logic        out_rtc_write;
  logic        out_cursor_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  clock_setting_key_controller_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_rtc_year_offset (in_rtc_year_offset),
    .in_rtc_month       (in_rtc_month),
    .in_rtc_day         (in_rtc_day),
    .in_rtc_hour        (in_rtc_hour),
    .in_rtc_minute      (in_rtc_minute),
    .in_rtc_second      (in_rtc_second),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_setting_mode   (out_setting_mode),
    .out_selected_field (out_selected_field),
    .out_year_offset    (out_year_offset),
    .out_month_index    (out_month_index),
    .out_day_of_month   (out_day_of_month),
    .out_hour_value     (out_hour_value),
    .out_minute_value   (out_minute_value),
    .out_second_value   (out_second_value),
    .out_rtc_write      (out_rtc_write),
    .out_cursor_on      (out_cursor_on)
  );

  // --------------------------------------------------------------------------
  // Bench state.
  // --------------------------------------------------------------------------
  item_t       key_events[$];       // beats waiting to be driven
  result_t     predicted_views[$];  // predicted result beats, oldest first
  int          idle_pct      = 28;  // chance in 100 that a side idles this cycle
  logic        in_accepted   = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned result_beats  = 0;
  int unsigned error_count   = 0;

  // Predictor copy of the controller state, at its reset values. Reset is
  // applied once at the start, so these initial values are the reset state.
  logic        set_mode    = 1'b0;
  logic [2:0]  set_field   = FLD_YEAR;
  logic [7:0]  set_year    = YEAR_FLOOR;
  logic [3:0]  set_month   = '0;
  logic [4:0]  set_day     = DAY_MIN;
  logic [4:0]  set_hour    = '0;
  logic [5:0]  set_minute  = '0;
  logic [5:0]  set_second  = '0;
  int unsigned blink_ticks = 0;
  logic [14:0] blink_half  = BLINK_RESET;

  // --------------------------------------------------------------------------
  // Predictor: applies one beat to the state copy and returns the display
  // the controller should show afterwards.
  // --------------------------------------------------------------------------
  task automatic predict_display(input item_t ev, output result_t view);
    int unsigned twice;
    logic        up;
    twice = 2 * blink_half;
    up    = (ev.kind == KIND_INC);
    view  = '0;
    case (ev.kind)
      KIND_TICK: begin
        // The counter saturates. In setting mode, passing a full blink cycle
        // restarts it.
        if (blink_ticks < BLINK_SAT) blink_ticks++;
        if (set_mode && blink_ticks > twice) blink_ticks = 0;
      end
      KIND_SEL: begin
        if (!set_mode) begin
          set_year   = ev.year;
          set_month  = ev.month;
          set_day    = ev.day;
          set_hour   = ev.hour;
          set_minute = ev.minute;
          set_second = ev.second;
          set_field  = FLD_YEAR;
          set_mode   = 1'b1;
        end else if (set_field >= FLD_SECOND) begin
          // Commit. The field code stays on second until the next entry.
          view.rtc_write = 1'b1;
          set_mode       = 1'b0;
        end else begin
          set_field = set_field + 3'd1;
        end
      end
      default: begin
        // Decrement and increment only matter in setting mode. Loaded values
        // beyond a field's limit follow the same wrap rules, so the month, hour,
        // minute and second limit tests are done one bit wider than the field.
        if (set_mode) begin
          case (set_field)
            FLD_YEAR: begin
              if (up) set_year = (set_year == YEAR_CEIL) ? YEAR_CEIL : set_year + 8'd1;
              else    set_year = (set_year <= YEAR_FLOOR) ? YEAR_FLOOR : set_year - 8'd1;
            end
            FLD_MONTH: begin
              if (up) set_month = ({1'b0, set_month} + 5'd1 > {1'b0, MONTH_MAX}) ?
                                  4'd0 : set_month + 4'd1;
              else    set_month = (set_month == 4'd0) ? MONTH_MAX : set_month - 4'd1;
            end
            FLD_DAY: begin
              if (up) set_day = (set_day >= DAY_MAX) ? DAY_MIN : set_day + 5'd1;
              else    set_day = (set_day <= DAY_MIN) ? DAY_MAX : set_day - 5'd1;
            end
            FLD_HOUR: begin
              if (up) set_hour = ({1'b0, set_hour} + 6'd1 > {1'b0, HOUR_MAX}) ?
                                 5'd0 : set_hour + 5'd1;
              else    set_hour = (set_hour == 5'd0) ? HOUR_MAX : set_hour - 5'd1;
            end
            FLD_MINUTE: begin
              if (up) set_minute = ({1'b0, set_minute} + 7'd1 > {1'b0, MINSEC_MAX}) ?
                                   6'd0 : set_minute + 6'd1;
              else    set_minute = (set_minute == 6'd0) ? MINSEC_MAX : set_minute - 6'd1;
            end
            FLD_SECOND: begin
              if (up) set_second = ({1'b0, set_second} + 7'd1 > {1'b0, MINSEC_MAX}) ?
                                   6'd0 : set_second + 6'd1;
              else    set_second = (set_second == 6'd0) ? MINSEC_MAX : set_second - 6'd1;
            end
            default: ;
          endcase
        end
      end
    endcase
    view.setting_mode   = set_mode;
    view.selected_field = set_field;
    view.year           = set_year;
    view.month          = set_month;
    view.day            = set_day;
    view.hour           = set_hour;
    view.minute         = set_minute;
    view.second         = set_second;
    // The cursor shows during the second half of each blink cycle. With a
    // zero half period that window is empty.
    view.cursor_on      = set_mode && blink_ticks > blink_half && blink_ticks <= twice;
  endtask

  // --------------------------------------------------------------------------
  // Error reporting. Every error prints one line and is counted.
  // --------------------------------------------------------------------------
  task automatic report_error(string msg);
    error_count++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_error($sformatf("result beat %0d, %s: got %0d, expected %0d",
                             result_beats, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Driver. At each falling edge, a beat that was taken at the last rising
  // edge, or an idle slot, is replaced by the next pending beat unless the
  // sender chooses to idle. A stalled beat is held unchanged. The result side
  // stall is drawn at random here too.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    item_t nxt;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < idle_pct);
      if (!in_valid || in_accepted) begin
        if (key_events.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = key_events.pop_front();
          in_kind            <= nxt.kind;
          in_rtc_year_offset <= nxt.year;
          in_rtc_month       <= nxt.month;
          in_rtc_day         <= nxt.day;
          in_rtc_hour        <= nxt.hour;
          in_rtc_minute      <= nxt.minute;
          in_rtc_second      <= nxt.second;
          in_valid           <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. At each rising edge it applies register writes and accepted
  // input beats to the predictor, and it checks each accepted result beat
  // against the oldest prediction. It also enforces the cycle limit.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    item_t   seen;
    result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (rst_n) begin
      // Writes only happen while the pipeline is empty, so applying them
      // before the beat of the same edge is safe.
      if (cfg_wr_en) blink_half = cfg_wr_data;

      if (in_valid && !in_stall) begin
        seen.kind   = in_kind;
        seen.year   = in_rtc_year_offset;
        seen.month  = in_rtc_month;
        seen.day    = in_rtc_day;
        seen.hour   = in_rtc_hour;
        seen.minute = in_rtc_minute;
        seen.second = in_rtc_second;
        predict_display(seen, want);
        predicted_views.push_back(want);
      end
      in_accepted <= in_valid && !in_stall;

      if (out_valid && !out_stall) begin
        if (predicted_views.size() == 0) begin
          report_error($sformatf("result beat %0d arrived with nothing predicted",
                                 result_beats));
        end else begin
          want = predicted_views.pop_front();
          check_field("setting_mode",   out_setting_mode,   want.setting_mode);
          check_field("selected_field", out_selected_field, want.selected_field);
          check_field("year_offset",    out_year_offset,    want.year);
          check_field("month_index",    out_month_index,    want.month);
          check_field("day_of_month",   out_day_of_month,   want.day);
          check_field("hour_value",     out_hour_value,     want.hour);
          check_field("minute_value",   out_minute_value,   want.minute);
          check_field("second_value",   out_second_value,   want.second);
          check_field("rtc_write",      out_rtc_write,      want.rtc_write);
          check_field("cursor_on",      out_cursor_on,      want.cursor_on);
        end
        result_beats++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Builds a beat whose clock time is mostly in range. Some beats sit at the
  // low or high limits, and a few use the full field widths so that the
  // out-of-range loads get exercised.
  function automatic item_t random_beat(logic [1:0] kind);
    item_t       ev;
    int unsigned mood;
    mood    = $urandom_range(9);
    ev.kind = kind;
    ev.year = 8'($urandom_range(255));
    case (mood)
      0: begin
        ev.year   = 8'd0;
        ev.month  = 4'd0;
        ev.day    = DAY_MIN;
        ev.hour   = 5'd0;
        ev.minute = 6'd0;
        ev.second = 6'd0;
      end
      1: begin
        ev.year   = YEAR_CEIL;
        ev.month  = MONTH_MAX;
        ev.day    = DAY_MAX;
        ev.hour   = HOUR_MAX;
        ev.minute = MINSEC_MAX;
        ev.second = MINSEC_MAX;
      end
      2: begin
        ev.month  = 4'($urandom_range(15));
        ev.day    = 5'($urandom_range(31));
        ev.hour   = 5'($urandom_range(31));
        ev.minute = 6'($urandom_range(63));
        ev.second = 6'($urandom_range(63));
      end
      default: begin
        ev.month  = 4'($urandom_range(11));
        ev.day    = 5'($urandom_range(31, 1));
        ev.hour   = 5'($urandom_range(23));
        ev.minute = 6'($urandom_range(59));
        ev.second = 6'($urandom_range(59));
      end
    endcase
    return ev;
  endfunction

  task automatic push_key(logic [1:0] kind);
    key_events.push_back(random_beat(kind));
  endtask

  // Random mix. Selects are frequent enough that most setting sessions
  // run all the way to a commit. Ticks keep the cursor moving.
  task automatic push_random_beats(int unsigned count);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 40)      push_key(KIND_TICK);
      else if (roll < 55) push_key(KIND_DEC);
      else if (roll < 70) push_key(KIND_INC);
      else                push_key(KIND_SEL);
    end
  endtask

  // Waits until every pending beat is driven and every prediction has been
  // matched, then gives the two-stage pipeline spare cycles to settle.
  task automatic wait_drained();
    while (key_events.size() > 0 || in_valid || predicted_views.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_blink_half(logic [14:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset half period. Keys in normal mode are
    // ignored. Then a session is loaded with the earliest time, so every
    // field wraps or clamps downward. Next comes a session loaded with day 0
    // and the largest values the other fields can hold, so every field saturates,
    // wraps or steps upward, including the out-of-range month, day, hour, minute and second.
    push_key(KIND_DEC);
    push_key(KIND_INC);
    key_events.push_back('{KIND_SEL, 8'd0, 4'd0, DAY_MIN, 5'd0, 6'd0, 6'd0});
    push_key(KIND_DEC);
    repeat (5) begin
      push_key(KIND_SEL);
      push_key(KIND_DEC);
    end
    push_key(KIND_SEL);
    key_events.push_back('{KIND_SEL, 8'hFF, 4'hF, 5'd0, 5'h1F, 6'h3F, 6'h3F});
    push_key(KIND_INC);
    repeat (5) begin
      push_key(KIND_SEL);
      push_key(KIND_INC);
    end
    push_key(KIND_SEL);
    wait_drained();

    // Smallest nonzero half period: while setting, the cursor shows on one tick in three.
    write_blink_half(15'd1);
    push_random_beats(210);
    wait_drained();

    // A small random half period, with neither side idling for the whole
    // phase.
    idle_pct = 0;
    write_blink_half(15'($urandom_range(40, 2)));
    push_random_beats(210);
    wait_drained();

    // A zero half period: the counter restarts on every tick while setting,
    // and the cursor never shows.
    idle_pct = 28;
    write_blink_half(15'd0);
    push_random_beats(210);
    wait_drained();

    // Largest half period. A short setting session keeps the count far below
    // the cursor window, so the cursor stays off. Idling is off here.
    idle_pct = 0;
    write_blink_half(15'h7FFF);
    push_key(KIND_SEL);
    repeat (40) push_key(KIND_TICK);
    push_key(KIND_INC);
    repeat (6) push_key(KIND_SEL);
    repeat (10) push_key(KIND_TICK);
    wait_drained();

    // Back to the reset half period, with random idling on both sides.
    idle_pct = 28;
    write_blink_half(BLINK_RESET);
    push_random_beats(210);
    wait_drained();

    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
